FILE: rtl/ddmf_pkg.sv
// ----------------------------------------------------------------------------
// ddmf_pkg
// Types, constants and codes shared by the differential drive motor framer.
// ----------------------------------------------------------------------------
package ddmf_pkg;

  localparam int VelWidth   = 16;
  localparam int QueueDepth = 4;
  localparam int QPtrWidth  = $clog2(QueueDepth);
  localparam int QCntWidth  = $clog2(QueueDepth + 1);
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 15;

  // thermometer steps of the speed map; the 15th step only matters below 2
  localparam int ThermSteps = 14;

  localparam logic [7:0] SyncByte     = 8'hAA;
  localparam logic [7:0] WheelIdLeft  = 8'h01;
  localparam logic [7:0] WheelIdRight = 8'h02;
  localparam logic [7:0] PadByte      = 8'h00;
  localparam logic       DriveModeStep = 1'b0;
  localparam logic       DriveModeRun  = 1'b1;
  localparam logic [4:0] ParamSlowest  = 5'd16;
  localparam logic [4:0] ParamStop     = 5'd0;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgStopThreshold = 3'd0,
    CfgSpinDeadband  = 3'd1,
    CfgFullSpeed     = 3'd2,
    CfgHalfTrack     = 3'd3,
    CfgSpinGain      = 3'd4,
    CfgSpinSpeedCap  = 3'd5
  } ddmf_cfg_idx_e;

  typedef enum logic [2:0] {
    ByteSync  = 3'd0,
    ByteId    = 3'd1,
    ByteMode  = 3'd2,
    ByteDir   = 3'd3,
    BytePad   = 3'd4,
    ByteParam = 3'd5
  } ddmf_byte_e;

  typedef struct packed {
    logic [14:0] stop_threshold;
    logic [14:0] spin_deadband;
    logic [14:0] full_speed;
    logic [11:0] half_track;
    logic [7:0]  spin_gain;
    logic [4:0]  spin_speed_cap;
  } ddmf_cfg_t;

  typedef struct packed {
    logic signed [VelWidth-1:0] linear_velocity;
    logic signed [VelWidth-1:0] angular_velocity;
  } ddmf_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
  } ddmf_out_t;

  // one word in the queue: everything the serializer needs for 12 bytes
  typedef struct packed {
    logic       mode;
    logic       dir_r;
    logic       dir_l;
    logic [4:0] param_r;
    logic [4:0] param_l;
  } ddmf_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ddmf_q_stat_t;

endpackage

FILE: rtl/ddmf_front.sv
// ----------------------------------------------------------------------------
// ddmf_front
// Classifies drive commands and works out direction and speed parameter for
// both wheels in a six stage pipeline, then pushes one word into the queue.
// ----------------------------------------------------------------------------
module ddmf_front import ddmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  ddmf_in_t  cmd_i,
  input  ddmf_cfg_t cfg_i,
  output logic      push_o,
  output ddmf_cmd_t push_cmd_o
);

  localparam int T1W = VelWidth + 10;   // w * gain
  localparam int T2W = T1W + 13;        // * half track
  localparam int SW  = T2W;             // wheel speed, Q.28
  localparam int TW  = SW - 11;         // (30 * |s|) >> 16
  localparam int ThrW = 20;             // 27 * full_speed

  function automatic logic [ThermSteps-1:0] therm_of(logic [TW-1:0] t, logic [14:0] fs);
    logic [ThermSteps-1:0] th;
    logic [ThrW-1:0]       thr;
    for (int k = 0; k < ThermSteps; k++) begin
      thr   = ThrW'(fs) * ThrW'(2 * k + 1);
      th[k] = (t >= TW'(thr));
    end
    return th;
  endfunction

  function automatic logic [4:0] param_of(logic [ThermSteps-1:0] th, logic zero,
                                          logic spin, logic [4:0] cap);
    logic [4:0] p;
    p = zero ? ParamSlowest : ParamSlowest - 5'($countones(th));
    if (spin && (p > cap)) begin
      p = cap;
    end
    return p;
  endfunction

  logic [VelWidth-1:0] va, wa;
  logic                stop_now, spin_now;

  logic [5:0] vld_q;

  logic signed [VelWidth-1:0] v0_q, w0_q, v1_q, v2_q;
  logic [8:0]                 mult0_q;
  logic signed [T1W-1:0]      term1_d, term1_q;
  logic signed [T2W-1:0]      term2_d, term2_q;
  logic signed [SW-1:0]       vext;
  logic signed [SW-1:0]       sr_d, sl_d, sr_q, sl_q;
  logic [SW-1:0]              ar, al;
  logic [SW+4:0]              pr30, pl30;
  logic [TW-1:0]              tr_q, tl_q;
  logic [ThermSteps-1:0]      thr_q, thl_q;
  logic [5:0]                 stop_q, spin_q;
  logic                       zr4_q, zl4_q, zr5_q, zl5_q;
  logic                       dr4_q, dl4_q, dr5_q, dl5_q;

  always_comb begin
    va = cmd_i.linear_velocity[VelWidth-1] ?
         (~cmd_i.linear_velocity + 1'b1) : cmd_i.linear_velocity;
    wa = cmd_i.angular_velocity[VelWidth-1] ?
         (~cmd_i.angular_velocity + 1'b1) : cmd_i.angular_velocity;
    stop_now = (va < VelWidth'(cfg_i.stop_threshold)) &&
               (wa < VelWidth'(cfg_i.stop_threshold));
    spin_now = (va < VelWidth'(cfg_i.spin_deadband)) &&
               (wa >= VelWidth'(cfg_i.stop_threshold));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept_i};
    end
  end

  always_comb begin
    term1_d = w0_q * $signed({1'b0, mult0_q});
    term2_d = term1_q * $signed({1'b0, cfg_i.half_track});
    vext    = {{(SW - VelWidth - 16){v2_q[VelWidth-1]}}, v2_q, 16'b0};
    sr_d    = vext + term2_q;
    sl_d    = vext - term2_q;
    ar      = sr_q[SW-1] ? -sr_q : sr_q;
    al      = sl_q[SW-1] ? -sl_q : sl_q;
    pr30    = {ar, 5'b0} - {4'b0, ar, 1'b0};
    pl30    = {al, 5'b0} - {4'b0, al, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    v0_q    <= cmd_i.linear_velocity;
    w0_q    <= cmd_i.angular_velocity;
    mult0_q <= spin_now ? {1'b0, cfg_i.spin_gain} : 9'd16;
    v1_q    <= v0_q;
    term1_q <= term1_d;
    v2_q    <= v1_q;
    term2_q <= term2_d;
    sr_q    <= sr_d;
    sl_q    <= sl_d;
    tr_q    <= pr30[SW+4:16];
    tl_q    <= pl30[SW+4:16];
    zr4_q   <= (sr_q == '0);
    zl4_q   <= (sl_q == '0);
    dr4_q   <= sr_q[SW-1];
    dl4_q   <= ~sl_q[SW-1];
    thr_q   <= therm_of(tr_q, cfg_i.full_speed);
    thl_q   <= therm_of(tl_q, cfg_i.full_speed);
    zr5_q   <= zr4_q;
    zl5_q   <= zl4_q;
    dr5_q   <= dr4_q;
    dl5_q   <= dl4_q;
    stop_q  <= {stop_q[4:0], stop_now};
    spin_q  <= {spin_q[4:0], spin_now};
  end

  always_comb begin
    push_o = vld_q[5];
    if (stop_q[5]) begin
      push_cmd_o.mode    = DriveModeStep;
      push_cmd_o.dir_r   = 1'b0;
      push_cmd_o.dir_l   = 1'b1;
      push_cmd_o.param_r = ParamStop;
      push_cmd_o.param_l = ParamStop;
    end else begin
      push_cmd_o.mode    = DriveModeRun;
      push_cmd_o.dir_r   = dr5_q;
      push_cmd_o.dir_l   = dl5_q;
      push_cmd_o.param_r = param_of(thr_q, zr5_q, spin_q[5], cfg_i.spin_speed_cap);
      push_cmd_o.param_l = param_of(thl_q, zl5_q, spin_q[5], cfg_i.spin_speed_cap);
    end
  end

endmodule

FILE: rtl/ddmf_queue.sv
// ----------------------------------------------------------------------------
// ddmf_queue
// Small FIFO of wheel command words between the front and the serializer.
// ----------------------------------------------------------------------------
module ddmf_queue import ddmf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ddmf_cmd_t    push_cmd_i,
  input  logic         pop_i,
  output ddmf_cmd_t    head_o,
  output ddmf_q_stat_t stat_o
);

  ddmf_cmd_t            mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] cnt_q;

  function automatic logic [QPtrWidth-1:0] ptr_inc(logic [QPtrWidth-1:0] p);
    return (p == QPtrWidth'(QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == QCntWidth'(QueueDepth));

endmodule

FILE: rtl/ddmf_back.sv
// ----------------------------------------------------------------------------
// ddmf_back
// Serializer: turns one command word into the right and left six-byte
// frames, one byte per cycle, through a registered output.
// ----------------------------------------------------------------------------
module ddmf_back import ddmf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ddmf_cmd_t    head_i,
  input  ddmf_q_stat_t stat_i,
  output logic         pop_o,
  output logic         out_valid_o,
  output ddmf_out_t    result_o
);

  logic       active_d, active_q;
  logic       left_d, left_q;
  ddmf_byte_e pos_d, pos_q;
  ddmf_cmd_t  cur_d, cur_q;
  logic       fin;
  logic       out_valid_q;
  ddmf_out_t  out_d, out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      left_q      <= 1'b0;
      pos_q       <= ByteSync;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      out_valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_comb begin
    fin      = !active_q || (left_q && (pos_q == ByteParam));
    pop_o    = fin && !stat_i.empty;
    active_d = active_q;
    left_d   = left_q;
    pos_d    = pos_q;
    cur_d    = cur_q;
    if (pop_o) begin
      active_d = 1'b1;
      left_d   = 1'b0;
      pos_d    = ByteSync;
      cur_d    = head_i;
    end else if (fin) begin
      active_d = 1'b0;
    end else if (pos_q == ByteParam) begin
      left_d = 1'b1;
      pos_d  = ByteSync;
    end else begin
      pos_d = ddmf_byte_e'(pos_q + 3'd1);
    end

    out_d.last = left_q && (pos_q == ByteParam);
    case (pos_q)
      ByteSync:  out_d.frame_byte = SyncByte;
      ByteId:    out_d.frame_byte = left_q ? WheelIdLeft : WheelIdRight;
      ByteMode:  out_d.frame_byte = {7'b0, cur_q.mode};
      ByteDir:   out_d.frame_byte = {7'b0, left_q ? cur_q.dir_l : cur_q.dir_r};
      BytePad:   out_d.frame_byte = PadByte;
      ByteParam: out_d.frame_byte = {3'b0, left_q ? cur_q.param_l : cur_q.param_r};
      default:   out_d.frame_byte = PadByte;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

FILE: rtl/diff_drive_motor_framer.sv
// ----------------------------------------------------------------------------
// diff_drive_motor_framer
// Turns drive commands into right and left motor frames, six bytes each.
// ----------------------------------------------------------------------------
//  channel   ports                             handshake
//  command   start, cmd_i, busy                taken when start & !busy
//  result    out_valid_o, result_o             one word per cycle, no stall
//  config    cfg_we_i, cfg_idx_i, cfg_data_i   written when cfg_we_i
//
// Every command gives 12 bytes, one per cycle from the serializer. The first
// byte of a command goes through the front pipeline, the queue and the
// serializer's state and output registers when the serializer is free.
// Up to four commands may be in flight; busy rises when that count is full.
// Reset puts the config registers at their defaults and empties the pipe.
// ----------------------------------------------------------------------------
module diff_drive_motor_framer import ddmf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  ddmf_in_t                cmd_i,
  output logic                    busy,
  output logic                    out_valid_o,
  output ddmf_out_t               result_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  ddmf_cfg_t            cfg_q;
  logic [QCntWidth-1:0] inflight_q;
  logic                 accept;
  logic                 push, pop;
  ddmf_cmd_t            push_cmd, head;
  ddmf_q_stat_t         q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_threshold <= 15'd41;
      cfg_q.spin_deadband  <= 15'd205;
      cfg_q.full_speed     <= 15'd2458;
      cfg_q.half_track     <= 12'd344;
      cfg_q.spin_gain      <= 8'd48;
      cfg_q.spin_speed_cap <= 5'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStopThreshold: cfg_q.stop_threshold <= cfg_data_i;
        CfgSpinDeadband:  cfg_q.spin_deadband  <= cfg_data_i;
        CfgFullSpeed:     cfg_q.full_speed     <= cfg_data_i;
        CfgHalfTrack:     cfg_q.half_track     <= cfg_data_i[11:0];
        CfgSpinGain:      cfg_q.spin_gain      <= cfg_data_i[7:0];
        CfgSpinSpeedCap:  cfg_q.spin_speed_cap <= cfg_data_i[4:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  // credits cover words in the front pipe plus words in the queue
  assign busy   = (inflight_q == QCntWidth'(QueueDepth));
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      case ({accept, pop})
        2'b10:   inflight_q <= inflight_q + 1'b1;
        2'b01:   inflight_q <= inflight_q - 1'b1;
        default: inflight_q <= inflight_q;
      endcase
    end
  end

  ddmf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  ddmf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  ddmf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .result_o    (result_o)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= QCntWidth'(QueueDepth))
    else $error("in-flight count past queue depth");

  a_last_then_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_o.last |=> out_valid_o)
    else $error("frame stream broken before last byte");
`endif

endmodule

FILE: tb/ddmf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ddmf_checker
// Watches the command, config and byte channels of the motor framer, works out
// the twelve frame bytes of each accepted command from its own copy of the
// registers, and compares every output word against the oldest prediction.
// ----------------------------------------------------------------------------
module ddmf_checker import ddmf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  ddmf_in_t                cmd_i,
  input  logic                    out_valid_i,
  input  ddmf_out_t               result_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output int                      err_count_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam logic [14:0] RstStopThreshold = 15'd41;
  localparam logic [14:0] RstSpinDeadband  = 15'd205;
  localparam logic [14:0] RstFullSpeed     = 15'd2458;
  localparam logic [11:0] RstHalfTrack     = 12'd344;
  localparam logic [7:0]  RstSpinGain      = 8'd48;
  localparam logic [4:0]  RstSpinSpeedCap  = 5'd6;
  localparam logic [4:0]  ParamFastest     = 5'd2;
  localparam longint      SpeedSteps       = 15;
  localparam longint      UnityGain        = 16;     // Q4.4 one
  localparam longint      LinearScale      = 65536;  // lines v up with the Q.28 term

  ddmf_cfg_t cfg;
  ddmf_out_t frame_q[$];
  ddmf_out_t exp_w;
  int        errors  = 0;
  int        checked = 0;

  assign err_count_o = errors;
  assign pending_o   = frame_q.size();
  assign checked_o   = checked;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // 16 - round(15 * min(|s| / full, 1)), floored at the fastest setting
  function automatic logic [4:0] speed_param(longint s_abs);
    longint full28;
    longint steps;
    if (s_abs == 0) return ParamSlowest;
    full28 = longint'(cfg.full_speed) << 16;
    if (full28 == 0 || s_abs >= full28) steps = SpeedSteps;
    else steps = (2 * SpeedSteps * s_abs + full28) / (2 * full28);
    if (longint'(ParamSlowest) - steps < longint'(ParamFastest)) return ParamFastest;
    return 5'(longint'(ParamSlowest) - steps);
  endfunction

  function automatic void push_frame(logic [7:0] id, logic mode, logic dir,
                                     logic [4:0] param, logic tail);
    ddmf_out_t w;
    for (int k = 0; k < 6; k++) begin
      case (ddmf_byte_e'(k))
        ByteSync:  w.frame_byte = SyncByte;
        ByteId:    w.frame_byte = id;
        ByteMode:  w.frame_byte = {7'd0, mode};
        ByteDir:   w.frame_byte = {7'd0, dir};
        BytePad:   w.frame_byte = PadByte;
        default:   w.frame_byte = {3'd0, param};
      endcase
      w.last = tail && (k == int'(ByteParam));
      frame_q.push_back(w);
    end
  endfunction

  function automatic void predict_frames(ddmf_in_t c);
    longint     lin, ang, lin_mag, ang_mag, gain, term, s_right, s_left;
    logic       spin;
    logic [4:0] p_right, p_left;
    lin     = longint'($signed(c.linear_velocity));
    ang     = longint'($signed(c.angular_velocity));
    lin_mag = (lin < 0) ? -lin : lin;
    ang_mag = (ang < 0) ? -ang : ang;

    if (lin_mag < longint'(cfg.stop_threshold) && ang_mag < longint'(cfg.stop_threshold)) begin
      push_frame(WheelIdRight, DriveModeStep, 1'b0, ParamStop, 1'b0);
      push_frame(WheelIdLeft,  DriveModeStep, 1'b1, ParamStop, 1'b1);
      return;
    end

    spin    = (lin_mag < longint'(cfg.spin_deadband)) &&
              (ang_mag >= longint'(cfg.stop_threshold));
    gain    = spin ? longint'(cfg.spin_gain) : UnityGain;
    term    = ang * gain * longint'(cfg.half_track);
    s_right = lin * LinearScale + term;
    s_left  = lin * LinearScale - term;
    p_right = speed_param((s_right < 0) ? -s_right : s_right);
    p_left  = speed_param((s_left < 0) ? -s_left : s_left);
    if (spin) begin
      if (p_right > cfg.spin_speed_cap) p_right = cfg.spin_speed_cap;
      if (p_left > cfg.spin_speed_cap) p_left = cfg.spin_speed_cap;
    end
    // left motor is mounted mirrored, so its direction bit is inverted
    push_frame(WheelIdRight, DriveModeRun, s_right < 0, p_right, 1'b0);
    push_frame(WheelIdLeft,  DriveModeRun, s_left >= 0, p_left,  1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.stop_threshold = RstStopThreshold;
      cfg.spin_deadband  = RstSpinDeadband;
      cfg.full_speed     = RstFullSpeed;
      cfg.half_track     = RstHalfTrack;
      cfg.spin_gain      = RstSpinGain;
      cfg.spin_speed_cap = RstSpinSpeedCap;
      frame_q.delete();
    end else begin
      if (out_valid_i) begin
        if (frame_q.size() == 0) begin
          report_mismatch($sformatf("word %0d with nothing expected: byte %h last %b",
                                    checked, result_i.frame_byte, result_i.last));
        end else begin
          exp_w = frame_q.pop_front();
          if (result_i.frame_byte !== exp_w.frame_byte)
            report_mismatch($sformatf("word %0d (byte %0d of frame pair): frame_byte %h, want %h",
                                      checked, checked % 12, result_i.frame_byte,
                                      exp_w.frame_byte));
          if (result_i.last !== exp_w.last)
            report_mismatch($sformatf("word %0d: last %b, want %b",
                                      checked, result_i.last, exp_w.last));
          checked++;
        end
      end
      if (start_i && !busy_i) predict_frames(cmd_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStopThreshold: cfg.stop_threshold = cfg_data_i[14:0];
          CfgSpinDeadband:  cfg.spin_deadband  = cfg_data_i[14:0];
          CfgFullSpeed:     cfg.full_speed     = cfg_data_i[14:0];
          CfgHalfTrack:     cfg.half_track     = cfg_data_i[11:0];
          CfgSpinGain:      cfg.spin_gain      = cfg_data_i[7:0];
          CfgSpinSpeedCap:  cfg.spin_speed_cap = cfg_data_i[4:0];
          default: ;  // unused indexes are dropped
        endcase
      end
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives drive commands and register writes into the motor framer: a directed
// set at reset values, then random commands under several register settings,
// extremes included. Checking is left to ddmf_checker.
// ----------------------------------------------------------------------------
module tb_top import ddmf_pkg::*; ();

  localparam int HalfPeriod     = 10;
  localparam int ResetCycles    = 10;
  localparam int CycleLimit     = 400000;
  localparam int DrainCycles    = 16;   // extra wait after the last expected byte is checked
  localparam int RandomPerPhase = 11;
  localparam int QuietFirst     = 40;   // commands in this window get no gaps
  localparam int QuietLast      = 75;
  localparam logic [CfgIdxWidth-1:0] CfgSpareLow  = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CfgSpareHigh = 3'd7;

  logic                    clk      = 1'b0;
  logic                    rst_n    = 1'b0;
  logic                    start    = 1'b0;
  ddmf_in_t                cmd      = '0;
  logic                    busy;
  logic                    out_valid;
  ddmf_out_t               result;
  logic                    cfg_we   = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx  = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  int errors, pending, checked;
  int cycles    = 0;
  int commands  = 0;
  int settings  = 1;
  int stop_lvl  = 41;
  int dead_lvl  = 205;

  always #(HalfPeriod) clk = ~clk;

  diff_drive_motor_framer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .cmd_i       (cmd),
    .busy        (busy),
    .out_valid_o (out_valid),
    .result_o    (result),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  ddmf_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .cmd_i       (cmd),
    .out_valid_i (out_valid),
    .result_i    (result),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d words outstanding", cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_drive(input logic signed [VelWidth-1:0] lin,
                            input logic signed [VelWidth-1:0] ang);
    if ((commands < QuietFirst || commands >= QuietLast) && $urandom_range(0, 99) < 11) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    start = 1'b1;
    cmd.linear_velocity  = lin;
    cmd.angular_velocity = ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    commands++;
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input int value);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CfgDataWidth'(value);
    @(negedge clk);
    cfg_we   = 1'b0;
  endtask

  task automatic apply_settings(input int st, input int dead, input int full,
                                input int ht, input int gain, input int cap,
                                input bit poke_spare);
    wait_idle();
    write_reg(CfgStopThreshold, st);
    write_reg(CfgSpinDeadband,  dead);
    write_reg(CfgFullSpeed,     full);
    write_reg(CfgHalfTrack,     ht);
    write_reg(CfgSpinGain,      gain);
    write_reg(CfgSpinSpeedCap,  cap);
    // writes to unused indexes must leave every register alone
    if (poke_spare) begin
      write_reg(CfgSpareLow,  32767);
      write_reg(CfgSpareHigh, 0);
    end
    stop_lvl = st;
    dead_lvl = dead;
    settings++;
  endtask

  // magnitude a few counts either side of a threshold, random sign
  function automatic logic signed [VelWidth-1:0] near_level(input int lvl);
    int m;
    m = lvl + int'($urandom_range(0, 8)) - 4;
    if (m < 0) m = 0;
    if (m > 32767) m = 32767;
    return VelWidth'($urandom_range(0, 1) ? -m : m);
  endfunction

  task automatic random_drive();
    logic signed [VelWidth-1:0] lin, ang;
    int unsigned shape;
    shape = $urandom_range(0, 99);
    lin   = VelWidth'($urandom);
    ang   = VelWidth'($urandom);
    if (shape < 25) begin
      lin = near_level(stop_lvl);
      ang = near_level(stop_lvl);
    end else if (shape < 50) begin
      lin = near_level(dead_lvl);  // around spin in place, any yaw rate
    end else if (shape < 60) begin
      lin = VelWidth'(int'($urandom_range(0, 600)) - 300);
      ang = VelWidth'(int'($urandom_range(0, 600)) - 300);
    end
    send_drive(lin, ang);
  endtask

  initial begin
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: stop band, spin band edges, full speed, rounding, extremes
    send_drive(0, 0);
    send_drive(40, -40);
    send_drive(-40, 40);
    send_drive(41, 0);
    send_drive(0, 41);
    send_drive(0, -41);
    send_drive(204, 2000);
    send_drive(205, 2000);
    send_drive(2458, 0);
    send_drive(-2458, 0);
    send_drive(1229, 0);
    send_drive(82, 0);
    send_drive(32767, 32767);
    send_drive(-32768, -32768);
    send_drive(32767, -32768);
    send_drive(-32768, 32767);
    send_drive(0, 32767);
    send_drive(0, -32768);
    send_drive(-32768, 0);
    send_drive(300, -300);

    for (int p = 0; p < 7; p++) begin
      case (p)
        1: apply_settings(32767, 32767, 32767, 4095, 255, 31, 1'b0);
        2: apply_settings(0, 0, 0, 0, 0, 0, 1'b1);
        // spinning whenever |lin| is below 32767, with a zero cap
        3: apply_settings(0, 32767, 1, 4095, 255, 0, 1'b0);
        4, 5: apply_settings($urandom_range(0, 300), $urandom_range(100, 4000),
                             $urandom_range(1, 4000), $urandom_range(0, 4095),
                             $urandom_range(0, 255), $urandom_range(0, 31), 1'b0);
        6: apply_settings(41, 205, 2458, 344, 48, 6, 1'b0);
        default: ;
      endcase
      if (p == 1) begin
        send_drive(32767, 0);
        send_drive(-32768, 32767);
      end
      for (int n = 0; n < RandomPerPhase; n++) random_drive();
    end

    wait_idle();
    $display("Ran %0d drive commands under %0d register settings, %0d frame bytes compared.",
             commands, settings, checked);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
rtl/ddmf_pkg.sv
rtl/ddmf_front.sv
rtl/ddmf_queue.sv
rtl/ddmf_back.sv
rtl/diff_drive_motor_framer.sv
tb/ddmf_checker.sv
tb/tb_top.sv
